// ===== rtl/sdfp_pkg.sv =====
// Shared types, codes and per-kind packet constants for the sensor frame parser.
`default_nettype none

package sdfp_pkg;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_KIND = 5'b00001,
        PH_TIME = 5'b00010,
        PH_SUB  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_SKIP = 5'b10000
    } phase_t;

    // Stream kinds as carried in the kind byte and on the result.
    localparam logic [1:0] KIND_ECG = 2'h0;
    localparam logic [1:0] KIND_PPG = 2'h1;
    localparam logic [1:0] KIND_ACC = 2'h2;
    localparam logic [1:0] KIND_PPI = 2'h3;

    // Subtype byte each kind must carry.
    localparam logic [7:0] SUB_DEFAULT = 8'h00;
    localparam logic [7:0] SUB_ACC     = 8'h01;

    localparam int unsigned TS_BYTES    = 8;
    localparam int unsigned SAMPLE_MAX  = 12;

    typedef logic [SAMPLE_MAX-1:0][7:0] sample_t;

    typedef struct packed {
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] c;
        logic [23:0] d;
    } values_t;

    // Bytes per sample for each kind.
    function automatic logic [3:0] sample_size(input logic [1:0] kind);
        logic [3:0] size;
        case (kind)
            KIND_ECG: size = 4'd3;
            KIND_PPG: size = 4'd12;
            KIND_ACC: size = 4'd6;
            default:  size = 4'd6;
        endcase
        return size;
    endfunction

    function automatic logic [7:0] sub_expect(input logic [1:0] kind);
        return (kind == KIND_ACC) ? SUB_ACC : SUB_DEFAULT;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sensor_data_frame_parser_core.sv =====
// Top level of the sensor data frame parser: byte parser, start-time store and result register.
// Usage
// The input channel (s_*) carries one word per cycle. With s_cmd low the word is a packet byte
// on s_data_byte, and s_end_of_packet marks the final byte of its packet. With s_cmd high the
// word is a restart command that clears the start time of stream s_stream_id; such a word
// gives no result and does not touch the packet being parsed. s_host_time is sampled on the
// final timestamp byte of a pulse interval packet and replaces a timestamp of zero.
// The result channel (m_*) gives one word per completed sample, with the time relative to the
// stream's start time, up to four raw values, the index within the batch and a batch-end mark.
// A result is registered and appears in the cycle after its last sample byte is accepted.
// Throughput: one input word every cycle unless stalled, set by the single result register;
// the parser itself finishes each byte in the cycle it is accepted.
// Stalls: s_ready stays high while the result register is empty or is being emptied in the
// same cycle, so a stalled receiver holds the parser only once a result is waiting.
// Reset (aresetn low, synchronous): the parser returns to awaiting a kind byte, all four
// start times clear to zero and the result register empties.
`default_nettype none

module sensor_data_frame_parser_core #(
    parameter int unsigned ECG_BATCH = 32,
    parameter int unsigned PPG_BATCH = 32,
    parameter int unsigned ACC_BATCH = 32,
    parameter int unsigned PPI_BATCH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_packet,
    input  wire logic [1:0]  s_stream_id,
    input  wire logic [63:0] s_host_time,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_stream_kind,
    output logic [63:0]      m_rel_time_ns,
    output logic [23:0]      m_value_a,
    output logic [23:0]      m_value_b,
    output logic [23:0]      m_value_c,
    output logic [23:0]      m_value_d,
    output logic [7:0]       m_sample_index,
    output logic             m_batch_end
);

    // Parser state.
    sdfp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       frame_kind_reg, frame_kind_next;
    logic [3:0]       byte_pos_reg, byte_pos_next;
    logic [7:0]       batch_count_reg, batch_count_next;
    logic [63:0]      rel_time_reg, rel_time_next;
    logic [63:0]      start_time_reg [4];
    logic [63:0]      start_time_next [4];

    // The first seven timestamp bytes; the eighth is used straight from the input.
    logic [7:0]       ts_bytes_reg [sdfp_pkg::TS_BYTES-1];
    logic             ts_we;
    logic [7:0]       sample_bytes_reg [sdfp_pkg::SAMPLE_MAX];
    logic             sample_we;

    // Result register.
    logic             m_valid_reg;
    logic [1:0]       m_kind_reg;
    logic [63:0]      m_rel_time_reg;
    sdfp_pkg::values_t m_values_reg;
    logic [7:0]       m_index_reg;
    logic             m_batch_end_reg;

    logic             accept;
    logic             data_word;
    logic [3:0]       pos_inc;
    logic [63:0]      ts_raw;
    logic [63:0]      ts_eff;
    logic [63:0]      start_eff;
    logic [7:0]       batch_cap;
    logic             batch_full;
    logic             emit;
    sdfp_pkg::sample_t cur_bytes;
    sdfp_pkg::values_t cur_values;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign data_word = accept && !s_cmd;
    assign pos_inc   = byte_pos_reg + 4'd1;

    // Full timestamp as it stands when its last byte arrives; interval packets that carry
    // zero take the host clock instead.
    always_comb begin
        ts_raw[63:56] = s_data_byte;
        for (int i = 0; i < sdfp_pkg::TS_BYTES - 1; i++) begin
            ts_raw[8*i +: 8] = ts_bytes_reg[i];
        end
    end

    assign ts_eff = (frame_kind_reg == sdfp_pkg::KIND_PPI && ts_raw == 64'd0) ?
                    s_host_time : ts_raw;

    // A stream whose start time is still zero takes this timestamp as its start.
    assign start_eff = (start_time_reg[frame_kind_reg] == 64'd0) ?
                       ts_eff : start_time_reg[frame_kind_reg];

    always_comb begin
        case (frame_kind_reg)
            sdfp_pkg::KIND_ECG: batch_cap = 8'(ECG_BATCH);
            sdfp_pkg::KIND_PPG: batch_cap = 8'(PPG_BATCH);
            sdfp_pkg::KIND_ACC: batch_cap = 8'(ACC_BATCH);
            default:            batch_cap = 8'(PPI_BATCH);
        endcase
    end

    assign batch_full = ({1'b0, batch_count_reg} + 9'd1) >= {1'b0, batch_cap};

    // Sample bytes with the arriving byte already in its slot.
    always_comb begin
        for (int i = 0; i < sdfp_pkg::SAMPLE_MAX; i++) begin
            cur_bytes[i] = (byte_pos_reg == 4'(i)) ? s_data_byte : sample_bytes_reg[i];
        end
    end

    sdfp_unpack u_unpack (
        .kind     (frame_kind_reg),
        .bytes_in (cur_bytes),
        .values   (cur_values)
    );

    always_comb begin
        phase_next       = phase_reg;
        frame_kind_next  = frame_kind_reg;
        byte_pos_next    = byte_pos_reg;
        batch_count_next = batch_count_reg;
        rel_time_next    = rel_time_reg;
        start_time_next  = start_time_reg;
        ts_we            = 1'b0;
        sample_we        = 1'b0;
        emit             = 1'b0;

        if (accept && s_cmd) begin
            start_time_next[s_stream_id] = 64'd0;
        end

        if (data_word) begin
            case (phase_reg)
                sdfp_pkg::PH_KIND: begin
                    if (s_data_byte[7:2] == 6'd0) begin
                        frame_kind_next = s_data_byte[1:0];
                        byte_pos_next   = 4'd0;
                        phase_next      = sdfp_pkg::PH_TIME;
                    end else begin
                        phase_next = sdfp_pkg::PH_SKIP;
                    end
                end
                sdfp_pkg::PH_TIME: begin
                    if (byte_pos_reg[2:0] == 3'd7) begin
                        start_time_next[frame_kind_reg] = start_eff;
                        rel_time_next = ts_eff - start_eff;
                        byte_pos_next = 4'd0;
                        phase_next    = sdfp_pkg::PH_SUB;
                    end else begin
                        ts_we         = 1'b1;
                        byte_pos_next = pos_inc;
                    end
                end
                sdfp_pkg::PH_SUB: begin
                    if (s_data_byte == sdfp_pkg::sub_expect(frame_kind_reg)) begin
                        byte_pos_next    = 4'd0;
                        batch_count_next = 8'd0;
                        phase_next       = sdfp_pkg::PH_DATA;
                    end else begin
                        phase_next = sdfp_pkg::PH_SKIP;
                    end
                end
                sdfp_pkg::PH_DATA: begin
                    sample_we     = 1'b1;
                    byte_pos_next = pos_inc;
                    if (pos_inc >= sdfp_pkg::sample_size(frame_kind_reg)) begin
                        emit             = 1'b1;
                        byte_pos_next    = 4'd0;
                        batch_count_next = batch_full ? 8'd0 : batch_count_reg + 8'd1;
                    end
                end
                sdfp_pkg::PH_SKIP: begin
                    phase_next = sdfp_pkg::PH_SKIP;
                end
                default: begin
                    phase_next = sdfp_pkg::PH_KIND;
                end
            endcase

            if (s_end_of_packet) begin
                phase_next       = sdfp_pkg::PH_KIND;
                byte_pos_next    = 4'd0;
                batch_count_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= sdfp_pkg::PH_KIND;
            byte_pos_reg    <= 4'd0;
            batch_count_reg <= 8'd0;
            for (int i = 0; i < 4; i++) begin
                start_time_reg[i] <= 64'd0;
            end
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            batch_count_reg <= batch_count_next;
            start_time_reg  <= start_time_next;
            if (s_ready) begin
                m_valid_reg <= emit;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        frame_kind_reg <= frame_kind_next;
        rel_time_reg   <= rel_time_next;
        if (ts_we) begin
            ts_bytes_reg[byte_pos_reg[2:0]] <= s_data_byte;
        end
        if (sample_we) begin
            sample_bytes_reg[byte_pos_reg] <= s_data_byte;
        end
        if (emit) begin
            m_kind_reg      <= frame_kind_reg;
            m_rel_time_reg  <= rel_time_reg;
            m_values_reg    <= cur_values;
            m_index_reg     <= batch_count_reg;
            m_batch_end_reg <= batch_full || s_end_of_packet;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_stream_kind  = m_kind_reg;
    assign m_rel_time_ns  = m_rel_time_reg;
    assign m_value_a      = m_values_reg.a;
    assign m_value_b      = m_values_reg.b;
    assign m_value_c      = m_values_reg.c;
    assign m_value_d      = m_values_reg.d;
    assign m_sample_index = m_index_reg;
    assign m_batch_end    = m_batch_end_reg;

endmodule

`default_nettype wire

// ===== rtl/sdfp_unpack.sv =====
// Splits one completed sample into its little-endian result values.
`default_nettype none

module sdfp_unpack (
    input  wire logic [1:0]      kind,
    input  wire sdfp_pkg::sample_t bytes_in,
    output sdfp_pkg::values_t    values
);

    always_comb begin
        values = '0;
        case (kind)
            sdfp_pkg::KIND_ECG: begin
                values.a = {bytes_in[2], bytes_in[1], bytes_in[0]};
            end
            sdfp_pkg::KIND_PPG: begin
                values.a = {bytes_in[2], bytes_in[1], bytes_in[0]};
                values.b = {bytes_in[5], bytes_in[4], bytes_in[3]};
                values.c = {bytes_in[8], bytes_in[7], bytes_in[6]};
                values.d = {bytes_in[11], bytes_in[10], bytes_in[9]};
            end
            sdfp_pkg::KIND_ACC: begin
                values.a = {8'h00, bytes_in[1], bytes_in[0]};
                values.b = {8'h00, bytes_in[3], bytes_in[2]};
                values.c = {8'h00, bytes_in[5], bytes_in[4]};
            end
            default: begin
                // Pulse interval: bpm, duration, error estimate, then flags.
                values.a = {16'h0000, bytes_in[0]};
                values.b = {8'h00, bytes_in[2], bytes_in[1]};
                values.c = {8'h00, bytes_in[4], bytes_in[3]};
                values.d = {21'h000000, bytes_in[5][2:0]};
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sdfp_checker.sv =====
// Port-level checks for the sensor data frame parser and their binding to the top level.
`default_nettype none

module sdfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_cmd,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_sample_index,
    input wire logic [63:0] m_rel_time_ns
);

    // A waiting result must stay valid and keep its time until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rel_time_ns))
        else $error("result word changed while stalled");

    // The input side is only held back by a waiting result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");

    // A restart command never produces a result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd |=> !m_valid)
        else $error("restart command produced a result");

    // Every new result word follows an accepted input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !($past(m_valid) && !$past(m_ready)) |-> $past(s_valid && s_ready))
        else $error("result word without an accepted input word");

    // A batch holds at most 255 samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_index != 8'hFF)
        else $error("sample index out of range");

endmodule

bind sensor_data_frame_parser_core sdfp_checker u_sdfp_checker (.*);

`default_nettype wire

// ===== verif/sensor_data_frame_parser_core_tb.sv =====
// Self-checking testbench for the sensor data frame parser core.
`timescale 1ns / 100ps

module sensor_data_frame_parser_core_tb;

    // Batch capacities. They are passed to the block so that both sides agree.
    localparam int unsigned ECG_CAP = 32;
    localparam int unsigned PPG_CAP = 32;
    localparam int unsigned ACC_CAP = 32;
    localparam int unsigned PPI_CAP = 32;
    localparam int unsigned BATCH_CAP [4] = '{ECG_CAP, PPG_CAP, ACC_CAP, PPI_CAP};

    // Bytes per sample, indexed by stream kind.
    localparam int unsigned SAMPLE_LEN [4] = '{3, 12, 6, 6};

    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned CALM_WORDS   = 120;   // final stretch with no idling
    localparam int unsigned DRAIN_AT     = 600;   // sender waits for all results here
    localparam int unsigned HOLD_AFTER   = 30;    // results before the long receiver hold
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned TAIL_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum logic {
        ENTRY_WORD,
        ENTRY_DRAIN
    } entry_kind_t;

    // One word waiting to be offered on the input channel, or a drain marker.
    typedef struct {
        entry_kind_t kind;
        logic        cmd;
        logic [7:0]  data;
        logic        eop;
        logic [1:0]  sid;
        logic [63:0] host;
    } out_word_t;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] rel;
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] c;
        logic [23:0] d;
        logic [7:0]  idx;
        logic        last;
    } sample_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [7:0]  s_data_byte;
    logic        s_end_of_packet;
    logic [1:0]  s_stream_id;
    logic [63:0] s_host_time;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_stream_kind;
    logic [63:0] m_rel_time_ns;
    logic [23:0] m_value_a;
    logic [23:0] m_value_b;
    logic [23:0] m_value_c;
    logic [23:0] m_value_d;
    logic [7:0]  m_sample_index;
    logic        m_batch_end;

    out_word_t   outbound_words [$];
    sample_rec_t awaited_samples [$];

    int unsigned error_count;
    int unsigned results_seen;
    int unsigned cycle_count;
    bit          word_taken;

    // Parser shadow state, kept in step with every accepted word.
    sdfp_pkg::phase_t phase_q;
    logic [1:0]  frame_kind_q;
    logic [3:0]  byte_pos;
    logic [63:0] stamp_acc;
    logic [63:0] start_ns [4];
    logic [63:0] rel_ns;
    logic [7:0]  smp [12];
    logic [7:0]  batch_pos;

    sensor_data_frame_parser_core #(
        .ECG_BATCH(ECG_CAP),
        .PPG_BATCH(PPG_CAP),
        .ACC_BATCH(ACC_CAP),
        .PPI_BATCH(PPI_CAP)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_data_byte    (s_data_byte),
        .s_end_of_packet(s_end_of_packet),
        .s_stream_id    (s_stream_id),
        .s_host_time    (s_host_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_stream_kind  (m_stream_kind),
        .m_rel_time_ns  (m_rel_time_ns),
        .m_value_a      (m_value_a),
        .m_value_b      (m_value_b),
        .m_value_c      (m_value_c),
        .m_value_d      (m_value_d),
        .m_sample_index (m_sample_index),
        .m_batch_end    (m_batch_end)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Timestamps lean towards the awkward values: zero (host time for interval
    // packets, and a stored start of zero is recaptured), all ones and small counts.
    function automatic logic [63:0] pick_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return '0;
        end else if (pick == 2) begin
            return '1;
        end else if (pick == 3) begin
            return 64'($urandom_range(0, 1000));
        end
        return rand64();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Advance the shadow parser by one accepted word and queue any sample it completes.
    task automatic parse_word(input logic cmd, input logic [7:0] b, input logic eop,
                              input logic [1:0] sid, input logic [63:0] host);
        logic [1:0]  k;
        logic [63:0] stamp;
        logic        full;
        sample_rec_t rec;
        k = frame_kind_q;
        // A restart only clears the stored start; it never ends the packet.
        if (cmd) begin
            start_ns[sid] = '0;
            return;
        end
        case (phase_q)
            sdfp_pkg::PH_KIND: begin
                if (b <= 8'd3) begin
                    frame_kind_q = b[1:0];
                    stamp_acc = '0;
                    byte_pos = '0;
                    phase_q = sdfp_pkg::PH_TIME;
                end else begin
                    phase_q = sdfp_pkg::PH_SKIP;
                end
            end
            sdfp_pkg::PH_TIME: begin
                stamp_acc = stamp_acc | (64'(b) << (8 * byte_pos[2:0]));
                byte_pos = byte_pos + 4'd1;
                if (byte_pos >= 4'd8) begin
                    stamp = stamp_acc;
                    if (k == sdfp_pkg::KIND_PPI && stamp == '0) begin
                        stamp = host;
                    end
                    if (start_ns[k] == '0) begin
                        start_ns[k] = stamp;
                    end
                    rel_ns = stamp - start_ns[k];
                    byte_pos = '0;
                    phase_q = sdfp_pkg::PH_SUB;
                end
            end
            sdfp_pkg::PH_SUB: begin
                if (b == ((k == sdfp_pkg::KIND_ACC) ? sdfp_pkg::SUB_ACC
                                                     : sdfp_pkg::SUB_DEFAULT)) begin
                    byte_pos = '0;
                    batch_pos = '0;
                    phase_q = sdfp_pkg::PH_DATA;
                end else begin
                    phase_q = sdfp_pkg::PH_SKIP;
                end
            end
            sdfp_pkg::PH_DATA: begin
                smp[byte_pos % 12] = b;
                byte_pos = byte_pos + 4'd1;
                if (byte_pos >= SAMPLE_LEN[k]) begin
                    full = (int'(batch_pos) + 1 >= int'(BATCH_CAP[k]));
                    byte_pos = '0;
                    rec.kind = k;
                    rec.rel  = rel_ns;
                    rec.b    = '0;
                    rec.c    = '0;
                    rec.d    = '0;
                    case (k)
                        sdfp_pkg::KIND_ECG: begin
                            rec.a = {smp[2], smp[1], smp[0]};
                        end
                        sdfp_pkg::KIND_PPG: begin
                            rec.a = {smp[2], smp[1], smp[0]};
                            rec.b = {smp[5], smp[4], smp[3]};
                            rec.c = {smp[8], smp[7], smp[6]};
                            rec.d = {smp[11], smp[10], smp[9]};
                        end
                        sdfp_pkg::KIND_ACC: begin
                            rec.a = {8'h00, smp[1], smp[0]};
                            rec.b = {8'h00, smp[3], smp[2]};
                            rec.c = {8'h00, smp[5], smp[4]};
                        end
                        default: begin
                            // Pulse interval: bpm, duration, error estimate, three flag bits.
                            rec.a = {16'h0000, smp[0]};
                            rec.b = {8'h00, smp[2], smp[1]};
                            rec.c = {8'h00, smp[4], smp[3]};
                            rec.d = {21'h0, smp[5][2:0]};
                        end
                    endcase
                    rec.idx  = batch_pos;
                    rec.last = full || eop;
                    batch_pos = full ? 8'd0 : batch_pos + 8'd1;
                    awaited_samples.push_back(rec);
                end
            end
            default: begin
            end
        endcase
        if (eop) begin
            phase_q = sdfp_pkg::PH_KIND;
            byte_pos = '0;
            batch_pos = '0;
        end
    endtask

    task automatic queue_word(input logic cmd, input logic [7:0] b, input logic eop,
                              input logic [1:0] sid);
        out_word_t w;
        w.kind = ENTRY_WORD;
        w.cmd  = cmd;
        w.data = b;
        w.eop  = eop;
        w.sid  = sid;
        w.host = rand64();
        outbound_words.push_back(w);
    endtask

    task automatic queue_drain();
        out_word_t w;
        w = '{ENTRY_DRAIN, 1'b0, 8'h00, 1'b0, 2'd0, 64'd0};
        outbound_words.push_back(w);
    endtask

    // Queue a packet: kind byte, little-endian stamp, subtype and payload, cut to
    // total_len bytes. fill < 0 gives random payload bytes. Restart commands are
    // slipped in between bytes at restart_pct percent.
    task automatic queue_packet(input logic [7:0] kind_byte, input logic [63:0] stamp,
                                input logic [7:0] sub, input int payload_len,
                                input int total_len, input int fill, input int restart_pct);
        logic [7:0] bytes_q [$];
        int         len;
        bytes_q.push_back(kind_byte);
        for (int i = 0; i < 8; i++) begin
            bytes_q.push_back(stamp[8*i +: 8]);
        end
        bytes_q.push_back(sub);
        for (int i = 0; i < payload_len; i++) begin
            bytes_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        len = (total_len > int'(bytes_q.size())) ? int'(bytes_q.size()) : total_len;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < restart_pct) begin
                queue_word(1'b1, 8'($urandom), 1'($urandom), 2'($urandom));
            end
            queue_word(1'b0, bytes_q[i], i == len - 1, 2'($urandom));
        end
    endtask

    // Stimulus: a directed opening, then random packets, then the end-of-run check.
    initial begin
        int unsigned choice;
        int unsigned kind;
        int unsigned samples;
        int          payload;
        logic [7:0]  sub_byte;
        bit          drain_queued;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_cmd           = 1'b0;
        s_data_byte     = 8'h00;
        s_end_of_packet = 1'b0;
        s_stream_id     = 2'd0;
        s_host_time     = '0;
        m_ready         = 1'b0;
        error_count     = 0;
        results_seen    = 0;
        word_taken      = 1'b0;
        phase_q         = sdfp_pkg::PH_KIND;
        frame_kind_q    = sdfp_pkg::KIND_ECG;
        byte_pos        = '0;
        stamp_acc       = '0;
        rel_ns          = '0;
        batch_pos       = '0;
        for (int i = 0; i < 4; i++) begin
            start_ns[i] = '0;
        end
        for (int i = 0; i < 12; i++) begin
            smp[i] = '0;
        end

        // Restart of every stream, with and without the end mark, which a command ignores.
        for (int i = 0; i < 4; i++) begin
            queue_word(1'b1, 8'($urandom), 1'(i), 2'(i));
        end
        // ECG with an all-ones stamp and extreme sample bytes.
        queue_packet({6'd0, sdfp_pkg::KIND_ECG}, '1, sdfp_pkg::SUB_DEFAULT, 3, 13, 255, 0);
        queue_packet({6'd0, sdfp_pkg::KIND_ECG}, 64'd5, sdfp_pkg::SUB_DEFAULT, 3, 13, 0, 0);
        queue_packet({6'd0, sdfp_pkg::KIND_PPG}, rand64(), sdfp_pkg::SUB_DEFAULT, 12, 22,
                     -1, 0);
        // Accelerometer with no payload at all.
        queue_packet({6'd0, sdfp_pkg::KIND_ACC}, rand64(), sdfp_pkg::SUB_ACC, 0, 10, -1, 0);
        // Interval packet with a zero stamp takes the host time; flags are masked.
        queue_packet({6'd0, sdfp_pkg::KIND_PPI}, '0, sdfp_pkg::SUB_DEFAULT, 6, 16, 255, 0);
        // Unknown kind, then wrong subtype, then a packet cut inside its stamp.
        queue_packet(8'hFF, rand64(), sdfp_pkg::SUB_DEFAULT, 2, 4, -1, 0);
        queue_packet({6'd0, sdfp_pkg::KIND_ECG}, rand64(), sdfp_pkg::SUB_ACC, 3, 13, -1, 0);
        queue_packet({6'd0, sdfp_pkg::KIND_PPG}, rand64(), sdfp_pkg::SUB_DEFAULT, 12, 4,
                     -1, 0);
        // ECG with a trailing partial sample, so the full sample carries no batch end.
        queue_packet({6'd0, sdfp_pkg::KIND_ECG}, rand64(), sdfp_pkg::SUB_DEFAULT, 5, 15,
                     -1, 0);
        queue_drain();

        drain_queued = 1'b0;
        while (outbound_words.size() < RANDOM_WORDS) begin
            if (!drain_queued && outbound_words.size() >= DRAIN_AT) begin
                queue_drain();
                drain_queued = 1'b1;
            end
            choice = $urandom_range(0, 99);
            kind = $urandom_range(0, 3);
            sub_byte = (kind == sdfp_pkg::KIND_ACC) ? sdfp_pkg::SUB_ACC : sdfp_pkg::SUB_DEFAULT;
            if (choice < 62) begin
                // Well-formed packet; now and then long enough to fill a batch.
                if ($urandom_range(0, 24) == 0) begin
                    kind = ($urandom_range(0, 1) == 0) ? 32'(sdfp_pkg::KIND_ECG)
                                                       : 32'(sdfp_pkg::KIND_ACC);
                    sub_byte = (kind == sdfp_pkg::KIND_ACC) ? sdfp_pkg::SUB_ACC
                                                            : sdfp_pkg::SUB_DEFAULT;
                    samples = $urandom_range(ACC_CAP - 1, ACC_CAP + 3);
                end else begin
                    samples = $urandom_range(0, 4);
                end
                payload = int'(samples * SAMPLE_LEN[kind]);
                if ($urandom_range(0, 3) == 0) begin
                    payload += int'($urandom_range(1, SAMPLE_LEN[kind] - 1));
                end
                queue_packet(8'(kind), pick_stamp(), sub_byte, payload, 10 + payload, -1, 2);
            end else if (choice < 70) begin
                queue_packet(8'($urandom_range(4, 255)), rand64(), sub_byte, 4,
                             int'($urandom_range(1, 14)), -1, 0);
            end else if (choice < 78) begin
                sub_byte = sub_byte ^ 8'($urandom_range(1, 255));
                queue_packet(8'(kind), pick_stamp(), sub_byte, 6, 16, -1, 0);
            end else if (choice < 86) begin
                queue_packet(8'(kind), pick_stamp(), sub_byte, 0,
                             int'($urandom_range(1, 10)), -1, 0);
            end else if (choice < 94) begin
                queue_word(1'b1, 8'($urandom), 1'($urandom), 2'($urandom));
            end else begin
                // Stray byte outside any packet framing.
                queue_word(1'b0, 8'($urandom), 1'($urandom), 2'($urandom));
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (outbound_words.size() != 0 || s_valid || awaited_samples.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Sender. A new word is loaded at the falling edge only once the previous one has
    // been taken; idle bursts are spent before the next word, and a drain marker
    // holds the channel quiet until every awaited sample has come back.
    int unsigned send_gap;
    initial send_gap = 0;

    always @(negedge aclk) begin
        out_word_t w;
        if (aresetn && (!s_valid || word_taken)) begin
            word_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (outbound_words.size() != 0 && outbound_words[0].kind == ENTRY_DRAIN) begin
                s_valid <= 1'b0;
                if (awaited_samples.size() == 0) begin
                    void'(outbound_words.pop_front());
                end
            end else if (outbound_words.size() != 0) begin
                w = outbound_words.pop_front();
                s_valid         <= 1'b1;
                s_cmd           <= w.cmd;
                s_data_byte     <= w.data;
                s_end_of_packet <= w.eop;
                s_stream_id     <= w.sid;
                s_host_time     <= w.host;
                if (outbound_words.size() > CALM_WORDS && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 7);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. Short random stalls, plus one long hold once some results have come,
    // so that the result register fills and the input is pushed back.
    int unsigned recv_stall;
    int unsigned long_hold;
    bit          held_once;
    initial begin
        recv_stall = 0;
        long_hold  = 0;
        held_once  = 1'b0;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (!held_once && results_seen >= HOLD_AFTER) begin
                held_once = 1'b1;
                long_hold = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (outbound_words.size() > CALM_WORDS && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor. Both handshakes are sampled at the rising edge; each result is checked
    // against the oldest awaited sample, then any accepted word advances the shadow parser.
    always @(posedge aclk) begin
        sample_rec_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_samples.size() == 0) begin
                    report_mismatch("result with no sample awaited", m_rel_time_ns, '0);
                end else begin
                    want = awaited_samples.pop_front();
                    if (m_stream_kind !== want.kind)
                        report_mismatch("stream_kind", 64'(m_stream_kind), 64'(want.kind));
                    if (m_rel_time_ns !== want.rel)
                        report_mismatch("rel_time_ns", m_rel_time_ns, want.rel);
                    if (m_value_a !== want.a)
                        report_mismatch("value_a", 64'(m_value_a), 64'(want.a));
                    if (m_value_b !== want.b)
                        report_mismatch("value_b", 64'(m_value_b), 64'(want.b));
                    if (m_value_c !== want.c)
                        report_mismatch("value_c", 64'(m_value_c), 64'(want.c));
                    if (m_value_d !== want.d)
                        report_mismatch("value_d", 64'(m_value_d), 64'(want.d));
                    if (m_sample_index !== want.idx)
                        report_mismatch("sample_index", 64'(m_sample_index), 64'(want.idx));
                    if (m_batch_end !== want.last)
                        report_mismatch("batch_end", 64'(m_batch_end), 64'(want.last));
                end
            end
            if (s_valid && s_ready) begin
                parse_word(s_cmd, s_data_byte, s_end_of_packet, s_stream_id, s_host_time);
                word_taken = 1'b1;
            end
        end
    end

    // Run guard.
    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// ===== sensor_data_frame_parser_core.f =====
rtl/sdfp_pkg.sv
rtl/sdfp_unpack.sv
rtl/sensor_data_frame_parser_core.sv
rtl/sdfp_checker.sv
verif/sensor_data_frame_parser_core_tb.sv
